FILE: rtl/overcurrent_monitor_debounced_top_defines.svh
// Assertion macros for the over-current monitor.
// Include where checks are written; expects aclk and aresetn in scope.
`ifndef OVERCURRENT_MONITOR_DEBOUNCED_TOP_DEFINES_SVH
`define OVERCURRENT_MONITOR_DEBOUNCED_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define OCMD_CHECK_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |-> (cond)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define OCMD_CHECK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/ocmd_pkg.sv
// Shared types and constants for the over-current monitor.
// No dependencies; imported by every module of the block.
package ocmd_pkg;

    localparam int SAMPLE_BITS     = 12;
    localparam int AVG_SAMPLES_DEF = 16;
    localparam int GAIN_W          = 24;
    localparam int FRAC_BITS       = 16;
    localparam int CURRENT_W       = 20;
    localparam int THRESH_W        = 20;
    localparam int COUNT_W         = 8;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMIT     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [GAIN_W-1:0]   GAIN_RESET      = 24'd1200290;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 20'd10000;
    localparam logic [COUNT_W-1:0]  LIMIT_RESET     = 8'd5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   calibrate;
    } in_t;

    typedef struct packed {
        logic [CURRENT_W-1:0] current_ma;
        logic [COUNT_W-1:0]   over_limit_count;
        logic                 overload;
        logic                 was_calibration;
    } out_t;

    // Window average beat between divider and scaler
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] avg;
        logic                   cal;
    } avg_beat_t;

    // Scaled current beat between scaler and trip logic
    typedef struct packed {
        logic [CURRENT_W-1:0] current_ma;
        logic                 cal;
    } ma_beat_t;

endpackage

FILE: rtl/ocmd_accum.sv
// Window accumulator: sums AVG_SAMPLES samples and emits one window-sum beat.
// Depends on ocmd_pkg.
module ocmd_accum #(
    parameter int AVG_SAMPLES = 16,
    parameter int SUM_W       = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ocmd_pkg::in_t  s_data,
    output logic           win_valid,
    input  logic           win_ready,
    output logic [SUM_W-1:0] win_sum,
    output logic           win_cal
);
    import ocmd_pkg::*;

    localparam int POS_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             win_valid_reg, win_valid_next;
    logic [SUM_W-1:0] win_sum_reg, win_sum_next;
    logic             win_cal_reg, win_cal_next;
    logic             in_fire;
    logic             last;
    logic [SUM_W-1:0] sum_total;

    // Take a sample unless a finished window beat is stuck
    assign s_ready   = !win_valid_reg || win_ready;
    assign in_fire   = s_valid && s_ready;
    assign last      = (pos_reg == POS_W'(AVG_SAMPLES - 1));
    assign sum_total = sum_reg + SUM_W'(s_data.sample);

    // Advance the running sum and close the window on its last sample
    always_comb begin
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        win_valid_next = win_valid_reg && !win_ready;
        win_sum_next   = win_sum_reg;
        win_cal_next   = win_cal_reg;
        if (in_fire) begin
            if (last) begin
                sum_next       = '0;
                pos_next       = '0;
                win_valid_next = 1'b1;
                win_sum_next   = sum_total;
                win_cal_next   = s_data.calibrate;
            end else begin
                sum_next = sum_total;
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            pos_reg       <= '0;
            win_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            win_valid_reg <= win_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge aclk) begin
        win_sum_reg <= win_sum_next;
        win_cal_reg <= win_cal_next;
    end

    assign win_valid = win_valid_reg;
    assign win_sum   = win_sum_reg;
    assign win_cal   = win_cal_reg;

endmodule

FILE: rtl/ocmd_divide.sv
// Window averager: truncating divide of the window sum by AVG_SAMPLES,
// done as a multiply by an exact reciprocal. Depends on ocmd_pkg.
module ocmd_divide #(
    parameter int AVG_SAMPLES = 16,
    parameter int SUM_W       = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                win_valid,
    output logic                win_ready,
    input  logic [SUM_W-1:0]    win_sum,
    input  logic                win_cal,
    output logic                avg_valid,
    input  logic                avg_ready,
    output ocmd_pkg::avg_beat_t avg_data
);
    import ocmd_pkg::*;

    localparam int LOG_N   = $clog2(AVG_SAMPLES);
    localparam int SHIFT   = SUM_W + LOG_N;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / N) gives the exact quotient for every SUM_W-bit sum
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    logic              avg_valid_reg, avg_valid_next;
    avg_beat_t         avg_reg, avg_next;
    logic [PROD_W-1:0] prod;
    logic              load;

    assign win_ready = !avg_valid_reg || avg_ready;
    assign load      = win_valid && win_ready;

    // Scale by the reciprocal and keep the quotient bits
    assign prod = PROD_W'(win_sum) * PROD_W'(RECIP);

    always_comb begin
        avg_valid_next = avg_valid_reg && !avg_ready;
        avg_next       = avg_reg;
        if (load) begin
            avg_valid_next = 1'b1;
            avg_next.avg   = prod[SHIFT +: SAMPLE_BITS];
            avg_next.cal   = win_cal;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_valid_reg <= 1'b0;
        end else begin
            avg_valid_reg <= avg_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg <= avg_next;
    end

    assign avg_valid = avg_valid_reg;
    assign avg_data  = avg_reg;

endmodule

FILE: rtl/ocmd_scale.sv
// Offset removal and Q16 gain scaling to milliamps; owns the zero offset.
// Depends on ocmd_pkg.
module ocmd_scale (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       avg_valid,
    output logic                       avg_ready,
    input  ocmd_pkg::avg_beat_t        avg_data,
    input  logic [ocmd_pkg::GAIN_W-1:0] gain_q16,
    output logic                       ma_valid,
    input  logic                       ma_ready,
    output ocmd_pkg::ma_beat_t         ma_data
);
    import ocmd_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + GAIN_W;

    logic [SAMPLE_BITS-1:0] offset_reg, offset_next;
    logic                   ma_valid_reg, ma_valid_next;
    ma_beat_t               ma_reg, ma_next;
    logic [SAMPLE_BITS-1:0] diff;
    logic [PROD_W-1:0]      prod;
    logic                   load;

    assign avg_ready = !ma_valid_reg || ma_ready;
    assign load      = avg_valid && avg_ready;

    // Subtract the offset, clamp at zero, apply the gain
    assign diff = (avg_data.avg > offset_reg) ? (avg_data.avg - offset_reg) : '0;
    assign prod = PROD_W'(diff) * PROD_W'(gain_q16);

    // The shifted product tops out below full scale, so no saturation stage
    always_comb begin
        offset_next   = offset_reg;
        ma_valid_next = ma_valid_reg && !ma_ready;
        ma_next       = ma_reg;
        if (load) begin
            ma_valid_next = 1'b1;
            ma_next.cal   = avg_data.cal;
            if (avg_data.cal) begin
                offset_next        = avg_data.avg;
                ma_next.current_ma = '0;
            end else begin
                ma_next.current_ma = prod[FRAC_BITS +: CURRENT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= '0;
            ma_valid_reg <= 1'b0;
        end else begin
            offset_reg   <= offset_next;
            ma_valid_reg <= ma_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ma_reg <= ma_next;
    end

    assign ma_valid = ma_valid_reg;
    assign ma_data  = ma_reg;

endmodule

FILE: rtl/ocmd_trip.sv
// Threshold compare, debounce counter and result output register.
// Depends on ocmd_pkg and the assertion macro header.
`include "overcurrent_monitor_debounced_top_defines.svh"

module ocmd_trip (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ma_valid,
    output logic                          ma_ready,
    input  ocmd_pkg::ma_beat_t            ma_data,
    input  logic [ocmd_pkg::THRESH_W-1:0] threshold,
    input  logic [ocmd_pkg::COUNT_W-1:0]  limit,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ocmd_pkg::out_t                m_data
);
    import ocmd_pkg::*;

    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    out_t               out_reg, out_next;
    logic               load;
    logic               over;

    assign ma_ready = !m_valid_reg || m_ready;
    assign load     = ma_valid && ma_ready;
    assign over     = ma_data.current_ma > threshold;

    // Count consecutive over-limit windows, stopping once past the limit; hold on calibration windows
    always_comb begin
        cnt_next = cnt_reg;
        if (load && !ma_data.cal) begin
            if (over) begin
                if ((cnt_reg <= limit) && (cnt_reg != {COUNT_W{1'b1}})) begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end else begin
                cnt_next = '0;
            end
        end
    end

    // Build the result beat
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        if (load) begin
            m_valid_next             = 1'b1;
            out_next.current_ma      = ma_data.current_ma;
            out_next.over_limit_count = cnt_next;
            out_next.overload        = cnt_next > limit;
            out_next.was_calibration = ma_data.cal;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `OCMD_CHECK_NOW(a_overload_vs_limit, m_valid_reg, out_reg.overload == (out_reg.over_limit_count > limit), "overload disagrees with count and limit")
    `OCMD_CHECK_NOW(a_pending_count, m_valid_reg, out_reg.over_limit_count == cnt_reg, "pending result count differs from counter")
    `OCMD_CHECK_NOW(a_cal_zero_current, m_valid_reg && out_reg.was_calibration, out_reg.current_ma == '0, "calibration beat carries nonzero current")
    `OCMD_CHECK_NEXT(a_cal_holds_count, load && ma_data.cal, cnt_reg == $past(cnt_reg), "calibration window changed the counter")

endmodule

FILE: rtl/overcurrent_monitor_debounced_top.sv
// Over-current monitor: window average, offset, Q16 scaling, debounced trip.
// Throughput: one sample per cycle unless m_ready holds the output; results leave through an output register.
// A window's result passes the window, reciprocal divide, gain multiply and trip registers
// in that order; the first loads when the window's last sample is taken.
// Reset (aresetn low, synchronous): sums, offset, counter and valids clear,
// configuration returns to its defaults; no clearing pass.
module overcurrent_monitor_debounced_top #(
    parameter int AVG_SAMPLES = ocmd_pkg::AVG_SAMPLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ocmd_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ocmd_pkg::out_t                  m_data,
    input  logic                            cfg_wr_en,
    input  logic [ocmd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ocmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ocmd_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES);

    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [THRESH_W-1:0] thresh_reg, thresh_next;
    logic [COUNT_W-1:0]  limit_reg, limit_next;

    logic             win_valid, win_ready, win_cal;
    logic [SUM_W-1:0] win_sum;
    logic             avg_valid, avg_ready;
    avg_beat_t        avg_data;
    logic             ma_valid, ma_ready;
    ma_beat_t         ma_data;

    // Decode configuration writes; drop unknown indexes
    always_comb begin
        gain_next   = gain_reg;
        thresh_next = thresh_reg;
        limit_next  = limit_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_GAIN:      gain_next   = cfg_wdata[GAIN_W-1:0];
                CFG_THRESHOLD: thresh_next = cfg_wdata[THRESH_W-1:0];
                CFG_LIMIT:     limit_next  = cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            thresh_reg <= THRESHOLD_RESET;
            limit_reg  <= LIMIT_RESET;
        end else begin
            gain_reg   <= gain_next;
            thresh_reg <= thresh_next;
            limit_reg  <= limit_next;
        end
    end

    ocmd_accum #(
        .AVG_SAMPLES(AVG_SAMPLES),
        .SUM_W      (SUM_W)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .win_valid(win_valid),
        .win_ready(win_ready),
        .win_sum  (win_sum),
        .win_cal  (win_cal)
    );

    ocmd_divide #(
        .AVG_SAMPLES(AVG_SAMPLES),
        .SUM_W      (SUM_W)
    ) u_divide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .win_valid(win_valid),
        .win_ready(win_ready),
        .win_sum  (win_sum),
        .win_cal  (win_cal),
        .avg_valid(avg_valid),
        .avg_ready(avg_ready),
        .avg_data (avg_data)
    );

    ocmd_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .avg_valid(avg_valid),
        .avg_ready(avg_ready),
        .avg_data (avg_data),
        .gain_q16 (gain_reg),
        .ma_valid (ma_valid),
        .ma_ready (ma_ready),
        .ma_data  (ma_data)
    );

    ocmd_trip u_trip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ma_valid (ma_valid),
        .ma_ready (ma_ready),
        .ma_data  (ma_data),
        .threshold(thresh_reg),
        .limit    (limit_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
